>>> hw/rtl/top_k_insertion_selector_macros.svh
// Assertion macros for the top-k selector RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TOP_K_INSERTION_SELECTOR_MACROS_SVH
`define TOP_K_INSERTION_SELECTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tkis_pkg.sv
// ----------------------------------------------------------------------------
// tkis_pkg
// Shared types, constants and the ranking compare of the top-k selector.
// ----------------------------------------------------------------------------
package tkis_pkg;

  localparam int unsigned TOP_K = 5;
  localparam int unsigned IdW   = 20;
  localparam int unsigned EnW   = 24;
  localparam int unsigned SizeW = 8;
  localparam int unsigned RankW = 4;

  localparam logic [RankW-1:0] LastRank = RankW'(TOP_K - 1);

  typedef enum logic [1:0] {
    MODE_BASE       = 2'd0,
    MODE_WORST      = 2'd1,
    MODE_SIZE_BASE  = 2'd2,
    MODE_SIZE_WORST = 2'd3
  } rank_mode_e;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_FLUSH = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [EnW-1:0]   base;
    logic [EnW-1:0]   worst;
    logic [SizeW-1:0] size_max;
  } entry_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic drain;  // insertion halted, chain only moves on shift
    logic shift;  // move every slot one place toward cell 0
  } cell_ctl_t;

  // True when candidate a ranks strictly ahead of entry b; smaller keys win.
  function automatic logic tkis_better(rank_mode_e mode, entry_t a, entry_t b);
    logic size_lt;
    logic size_eq;
    size_lt = a.size_max < b.size_max;
    size_eq = a.size_max == b.size_max;
    case (mode)
      MODE_BASE:       tkis_better = a.base < b.base;
      MODE_WORST:      tkis_better = a.worst < b.worst;
      MODE_SIZE_BASE:  tkis_better = size_lt || (size_eq && (a.base < b.base));
      MODE_SIZE_WORST: tkis_better = size_lt || (size_eq && (a.worst < b.worst));
      default:         tkis_better = 1'b0;
    endcase
  endfunction

endpackage

>>> hw/rtl/top_k_insertion_selector.sv
// ----------------------------------------------------------------------------
// top_k_insertion_selector
// Keeps the best TOP_K candidates of a stream in ranked order.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid_i/in_stall_o and are accepted one per cycle
// while a run is open. Each item enters cell 0 of a chain of TOP_K cells and
// its displaced entry moves one cell per cycle. An item with last_item_i set
// closes the run: input stalls while the last carries settle down the chain,
// then the chain shifts toward cell 0 and emits TOP_K results, rank 0 first,
// on out_valid_o/out_stall_i through one output register. An output stall
// holds the drain, and input opens again once the last result is loaded
// into the output register. Draining shifts empty entries in, so the list
// starts the next run empty. Reset empties the list, clears out_valid_o and
// sets rank_mode to base. cfg_we_i writes rank_mode; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
module top_k_insertion_selector
  import tkis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [IdW-1:0]   item_id_i,
  input  logic [EnW-1:0]   en_base_i,
  input  logic [EnW-1:0]   en_alt_one_i,
  input  logic [EnW-1:0]   en_alt_two_i,
  input  logic [SizeW-1:0] size_total_n_i,
  input  logic [SizeW-1:0] size_total_m_i,
  input  logic             last_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RankW-1:0] rank_o,
  output logic             ranked_valid_o,
  output logic [IdW-1:0]   ranked_id_o,
  output logic             last_of_run_o
);

  `include "top_k_insertion_selector_macros.svh"

  rank_mode_e       mode_q;
  state_e           state_q, state_d;
  logic [RankW-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             load;
  cell_ctl_t        ctl;
  entry_t           in_entry;
  entry_t           slot  [TOP_K];
  entry_t           carry [TOP_K];
  logic [TOP_K-1:0] slot_vld;
  logic [TOP_K-1:0] carry_vld;
  logic [EnW-1:0]   alt_max;

  logic             out_valid_q, out_valid_d;
  logic [RankW-1:0] rank_q;
  logic             rvalid_q;
  logic [IdW-1:0]   rid_q;
  logic             rlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BASE;
    end else if (cfg_we_i) begin
      mode_q <= rank_mode_e'(cfg_data_i);
    end
  end

  assign in_stall_o = (state_q != ST_RUN);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);

  assign alt_max = (en_alt_one_i > en_alt_two_i) ? en_alt_one_i : en_alt_two_i;

  always_comb begin
    in_entry.valid    = accept;
    in_entry.id       = item_id_i;
    in_entry.base     = en_base_i;
    in_entry.worst    = (alt_max > en_base_i) ? alt_max : en_base_i;
    in_entry.size_max = (size_total_n_i > size_total_m_i) ? size_total_n_i : size_total_m_i;
  end

  assign ctl.drain = (state_q == ST_DRAIN);
  assign ctl.shift = load;

  for (genvar k = 0; k < TOP_K; k++) begin : g_cell
    entry_t cin;
    entry_t up;
    if (k == 0) begin : g_head
      assign cin = in_entry;
    end else begin : g_body
      assign cin = carry[k-1];
    end
    if (k == TOP_K - 1) begin : g_tail
      assign up = '0;
    end else begin : g_mid
      assign up = slot[k+1];
    end
    tkis_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (mode_q),
      .ctl_i   (ctl),
      .carry_i (cin),
      .up_i    (up),
      .slot_o  (slot[k]),
      .carry_o (carry[k])
    );
    assign slot_vld[k]  = slot[k].valid;
    assign carry_vld[k] = carry[k].valid;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_RUN: begin
        if (accept && last_item_i) begin
          state_d = ST_FLUSH;
          cnt_d   = '0;
        end
      end
      ST_FLUSH: begin
        if (cnt_q == LastRank) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (load) begin
          if (cnt_q == LastRank) begin
            state_d = ST_RUN;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rank_q   <= cnt_q;
      rvalid_q <= slot[0].valid;
      rid_q    <= slot[0].valid ? slot[0].id : '0;
      rlast_q  <= (cnt_q == LastRank);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rank_o         = rank_q;
  assign ranked_valid_o = rvalid_q;
  assign ranked_id_o    = rid_q;
  assign last_of_run_o  = rlast_q;

  `TKIS_ASSERT_NOW(a_drain_no_carry, state_q == ST_DRAIN, carry_vld == '0,
                   "carry still moving while the list drains")
  `TKIS_ASSERT_NEXT(a_list_empty_after_run,
                    load && (cnt_q == LastRank), slot_vld == '0,
                    "list not empty after the last result of a run")
  `TKIS_ASSERT_NOW(a_last_flag_rank, out_valid_q && rlast_q, rank_q == LastRank,
                   "last-of-run flag on a result that is not the final rank")

endmodule

>>> hw/rtl/tkis_cell.sv
// ----------------------------------------------------------------------------
// tkis_cell
// One slot of the insertion chain with its carry register toward the next.
// ----------------------------------------------------------------------------
module tkis_cell
  import tkis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rank_mode_e mode_i,
  input  cell_ctl_t  ctl_i,
  input  entry_t     carry_i,
  input  entry_t     up_i,
  output entry_t     slot_o,
  output entry_t     carry_o
);

  entry_t slot_q, slot_d;
  entry_t carry_q, carry_d;
  logic   swap;

  // An empty carry never swaps, so it moves nothing further down.
  assign swap = carry_i.valid && (!slot_q.valid || tkis_better(mode_i, carry_i, slot_q));

  always_comb begin
    slot_d  = slot_q;
    carry_d = carry_q;
    if (ctl_i.shift) begin
      slot_d  = up_i;
      carry_d = '0;
    end else if (!ctl_i.drain) begin
      if (swap) begin
        slot_d  = carry_i;
        carry_d = slot_q;
      end else begin
        carry_d = carry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      carry_q <= '0;
    end else begin
      slot_q  <= slot_d;
      carry_q <= carry_d;
    end
  end

  assign slot_o  = slot_q;
  assign carry_o = carry_q;

endmodule
